### rtl/cwim_pkg.sv
// Shared types, constants and microcode program of the convolution window index map.
package cwim_pkg;

    localparam int MAX_DIM_DEF    = 64;
    localparam int MAX_DEPTH_DEF  = 64;
    localparam int MAX_FILTER_DEF = 8;
    localparam int MAX_RESULTS    = 64;
    localparam int STRIDE_MAX     = 8;

    localparam int DIM_W      = 7;
    localparam int FLT_W      = 4;
    localparam int STR_W      = 4;
    localparam int PAD_W      = 3;
    localparam int POS_W      = 6;
    localparam int IIDX_W     = 18;
    localparam int FIDX_W     = 12;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IN_ROWS,
        REG_IN_COLS,
        REG_IN_DEPTH,
        REG_FILTER_ROWS,
        REG_FILTER_COLS,
        REG_STRIDE,
        REG_PADDING
    } reg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0] in_rows;
        logic [DIM_W-1:0] in_cols;
        logic [DIM_W-1:0] in_depth;
        logic [FLT_W-1:0] filter_rows;
        logic [FLT_W-1:0] filter_cols;
        logic [STR_W-1:0] stride;
        logic [PAD_W-1:0] padding;
    } cwim_cfg_t;

    // datapath operation selected by the current control word
    typedef enum logic [2:0] {
        OP_WAIT,
        OP_MUL,
        OP_CHECK,
        OP_ROW,
        OP_TAP,
        OP_ERR,
        OP_EMPTY
    } op_t;

    typedef enum logic [1:0] {
        CD_NEXT,
        CD_INPUT,
        CD_CHECK,
        CD_EMIT
    } cond_t;

    localparam int PC_W = 3;
    typedef logic [PC_W-1:0] pc_t;

    localparam pc_t PC_IDLE  = 3'd0;
    localparam pc_t PC_MUL   = 3'd1;
    localparam pc_t PC_CHECK = 3'd2;
    localparam pc_t PC_ROW   = 3'd3;
    localparam pc_t PC_TAP   = 3'd4;
    localparam pc_t PC_ERR   = 3'd5;
    localparam pc_t PC_EMPTY = 3'd6;
    localparam pc_t PC_LAST  = PC_EMPTY;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        pc_t   tgt_a;
        pc_t   tgt_b;
    } uword_t;

    typedef struct packed {
        logic in_go;
        logic err;
        logic empty;
        logic emit_ok;
        logic done;
        logic row_end;
    } flags_t;

    // control store
    function automatic uword_t ucode_rom(pc_t pc);
        uword_t w;
        case (pc)
            PC_IDLE:  w = '{op: OP_WAIT,  cond: CD_INPUT, tgt_a: PC_MUL,   tgt_b: PC_IDLE};
            PC_MUL:   w = '{op: OP_MUL,   cond: CD_NEXT,  tgt_a: PC_CHECK, tgt_b: PC_CHECK};
            PC_CHECK: w = '{op: OP_CHECK, cond: CD_CHECK, tgt_a: PC_ERR,   tgt_b: PC_EMPTY};
            PC_ROW:   w = '{op: OP_ROW,   cond: CD_NEXT,  tgt_a: PC_TAP,   tgt_b: PC_TAP};
            PC_TAP:   w = '{op: OP_TAP,   cond: CD_EMIT,  tgt_a: PC_IDLE,  tgt_b: PC_ROW};
            PC_ERR:   w = '{op: OP_ERR,   cond: CD_EMIT,  tgt_a: PC_IDLE,  tgt_b: PC_IDLE};
            PC_EMPTY: w = '{op: OP_EMPTY, cond: CD_EMIT,  tgt_a: PC_IDLE,  tgt_b: PC_IDLE};
            default:  w = '{op: OP_WAIT,  cond: CD_INPUT, tgt_a: PC_MUL,   tgt_b: PC_IDLE};
        endcase
        return w;
    endfunction

endpackage

### rtl/cwim_cfg.sv
// Configuration register file with range saturation on write.
module cwim_cfg #(
    parameter int MAX_DIM    = cwim_pkg::MAX_DIM_DEF,
    parameter int MAX_DEPTH  = cwim_pkg::MAX_DEPTH_DEF,
    parameter int MAX_FILTER = cwim_pkg::MAX_FILTER_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cwim_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cwim_pkg::CFG_DATA_W-1:0] cfg_data,
    output cwim_pkg::cwim_cfg_t             cfg
);
    import cwim_pkg::*;

    localparam int DIM_LIM = (1 << DIM_W) - 1;
    localparam int FLT_LIM = (1 << FLT_W) - 1;
    localparam int DIM_CAP = (MAX_DIM < DIM_LIM) ? MAX_DIM : DIM_LIM;
    localparam int DEP_CAP = (MAX_DEPTH < DIM_LIM) ? MAX_DEPTH : DIM_LIM;
    localparam int FLT_CAP = (MAX_FILTER < FLT_LIM) ? MAX_FILTER : FLT_LIM;

    cwim_cfg_t cfg_reg;

    function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] v, int cap);
        logic [DIM_W-1:0] r;
        if (v == '0) r = DIM_W'(1);
        else if (int'(v) > cap) r = DIM_W'(cap);
        else r = v;
        return r;
    endfunction

    function automatic logic [FLT_W-1:0] clamp_flt(logic [FLT_W-1:0] v, int cap);
        logic [FLT_W-1:0] r;
        if (v == '0) r = FLT_W'(1);
        else if (int'(v) > cap) r = FLT_W'(cap);
        else r = v;
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.in_rows     <= DIM_W'(1);
            cfg_reg.in_cols     <= DIM_W'(1);
            cfg_reg.in_depth    <= DIM_W'(1);
            cfg_reg.filter_rows <= FLT_W'(1);
            cfg_reg.filter_cols <= FLT_W'(1);
            cfg_reg.stride      <= STR_W'(1);
            cfg_reg.padding     <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_IN_ROWS:     cfg_reg.in_rows     <= clamp_dim(cfg_data, DIM_CAP);
                REG_IN_COLS:     cfg_reg.in_cols     <= clamp_dim(cfg_data, DIM_CAP);
                REG_IN_DEPTH:    cfg_reg.in_depth    <= clamp_dim(cfg_data, DEP_CAP);
                REG_FILTER_ROWS: cfg_reg.filter_rows <= clamp_flt(cfg_data[FLT_W-1:0], FLT_CAP);
                REG_FILTER_COLS: cfg_reg.filter_cols <= clamp_flt(cfg_data[FLT_W-1:0], FLT_CAP);
                REG_STRIDE:      cfg_reg.stride <= clamp_flt(cfg_data[STR_W-1:0], STRIDE_MAX);
                REG_PADDING:     cfg_reg.padding     <= cfg_data[PAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

### rtl/cwim_useq.sv
// Microcode sequencer: step counter, control store lookup and conditional jumps.
module cwim_useq (
    input  logic              aclk,
    input  logic              aresetn,
    input  cwim_pkg::flags_t  flags,
    output cwim_pkg::uword_t  uop
);
    import cwim_pkg::*;

    pc_t pc_reg;
    pc_t pc_next;

    assign uop = ucode_rom(pc_reg);

    always_comb begin
        pc_next = pc_reg;
        case (uop.cond)
            CD_NEXT:  pc_next = uop.tgt_a;
            CD_INPUT: pc_next = flags.in_go ? uop.tgt_a : pc_reg;
            CD_CHECK: begin
                if (flags.err) pc_next = uop.tgt_a;
                else if (flags.empty) pc_next = uop.tgt_b;
                else pc_next = pc_reg + PC_W'(1);
            end
            CD_EMIT: begin
                // hold the step while the output register is occupied
                if (!flags.emit_ok) pc_next = pc_reg;
                else if (flags.done) pc_next = uop.tgt_a;
                else if (flags.row_end) pc_next = uop.tgt_b;
                else pc_next = pc_reg;
            end
            default: pc_next = PC_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= PC_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    a_pc_in_program: assert property (@(posedge aclk) disable iff (!aresetn)
        pc_reg <= PC_LAST)
        else $error("step counter left the program");

endmodule

### rtl/cwim_dp.sv
// Window address datapath: input latch, setup multiplies, tap bounds, address adders, output register.
module cwim_dp (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  cwim_pkg::cwim_cfg_t            cfg,
    input  cwim_pkg::uword_t               uop,
    output cwim_pkg::flags_t               flags,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [cwim_pkg::POS_W-1:0]     s_out_row,
    input  logic [cwim_pkg::POS_W-1:0]     s_out_col,
    input  logic [cwim_pkg::POS_W-1:0]     s_channel,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [cwim_pkg::IIDX_W-1:0]    m_input_index,
    output logic [cwim_pkg::FIDX_W-1:0]    m_filter_index,
    output logic                           m_valid_res,
    output logic                           m_range_error,
    output logic                           m_last
);
    import cwim_pkg::*;

    localparam int ST_W  = POS_W + STR_W;
    localparam int RB_W  = POS_W + DIM_W;
    localparam int FF_W  = 2 * FLT_W;
    localparam int AX_W  = ST_W + 2;
    localparam int RS_W  = RB_W + 2;
    localparam int N_W   = $clog2(MAX_RESULTS);
    localparam int LIM_W = ST_W + 1;

    typedef struct packed {
        logic [FLT_W-1:0] lo;
        logic [FLT_W-1:0] hi;
        logic             empty;
    } axis_t;

    logic [POS_W-1:0]  orow_reg, ocol_reg, ch_reg;
    logic [ST_W-1:0]   rstart_reg, cstart_reg;
    logic [RB_W-1:0]   rowbase_reg;
    logic [FF_W-1:0]   frfc_reg;
    logic              ch_ok_reg;
    logic [FIDX_W-1:0] fbase_reg, frow_reg;
    logic [IIDX_W-1:0] rowaddr_reg;
    logic [FLT_W-1:0]  i_reg, j_reg, i_lo_reg, i_hi_reg, j_lo_reg, j_hi_reg;
    logic [N_W-1:0]    n_reg;

    logic              m_valid_reg;
    logic [IIDX_W-1:0] m_input_index_reg;
    logic [FIDX_W-1:0] m_filter_index_reg;
    logic              m_valid_res_reg, m_range_error_reg, m_last_reg;

    axis_t              row_ax, col_ax;
    logic               range_bad;
    logic               emit_ok, emit_op, emit_fire, tap_last, row_end;
    logic [RS_W-1:0]    rsum;
    logic [RS_W+DIM_W-1:0] rprod;
    logic [FF_W-1:0]    ifc;
    logic [POS_W+FF_W-1:0] fbase_full;

    // first and last filter tap that lands inside the unpadded plane on one axis
    function automatic axis_t axis_bounds(logic [PAD_W-1:0] pad, logic [DIM_W-1:0] size,
                                          logic [ST_W-1:0] start, logic [FLT_W-1:0] fsize);
        logic signed [AX_W-1:0] lo_s, hi_s, fm1_s, max_s;
        axis_t a;
        lo_s  = $signed(AX_W'(pad)) - $signed(AX_W'(start));
        hi_s  = $signed(AX_W'(pad)) + $signed(AX_W'(size)) - $signed(AX_W'(start))
              - $signed(AX_W'(1));
        fm1_s = $signed(AX_W'(fsize)) - $signed(AX_W'(1));
        max_s = (hi_s < fm1_s) ? hi_s : fm1_s;
        a.lo  = (lo_s > $signed(AX_W'(0))) ? lo_s[FLT_W-1:0] : '0;
        a.hi  = max_s[FLT_W-1:0];
        a.empty = $signed(AX_W'(a.lo)) > max_s;
        return a;
    endfunction

    assign row_ax = axis_bounds(cfg.padding, cfg.in_rows, rstart_reg, cfg.filter_rows);
    assign col_ax = axis_bounds(cfg.padding, cfg.in_cols, cstart_reg, cfg.filter_cols);

    // window must fit in the padded plane: start + filter <= size + 2*pad
    assign range_bad = !ch_ok_reg
        || ((LIM_W'(rstart_reg) + LIM_W'(cfg.filter_rows))
            > (LIM_W'(cfg.in_rows) + LIM_W'({cfg.padding, 1'b0})))
        || ((LIM_W'(cstart_reg) + LIM_W'(cfg.filter_cols))
            > (LIM_W'(cfg.in_cols) + LIM_W'({cfg.padding, 1'b0})));

    assign emit_ok   = !m_valid_reg || m_ready;
    assign emit_op   = (uop.op == OP_TAP) || (uop.op == OP_ERR) || (uop.op == OP_EMPTY);
    assign emit_fire = emit_ok && emit_op;
    assign row_end   = (j_reg == j_hi_reg);
    assign tap_last  = (row_end && (i_reg == i_hi_reg)) || (n_reg == N_W'(MAX_RESULTS - 1));

    assign s_ready = (uop.op == OP_WAIT);

    assign flags.in_go   = s_valid;
    assign flags.err     = range_bad;
    assign flags.empty   = row_ax.empty || col_ax.empty;
    assign flags.emit_ok = emit_ok;
    assign flags.done    = (uop.op == OP_TAP) ? tap_last : 1'b1;
    assign flags.row_end = row_end;

    assign rsum  = RS_W'(rowbase_reg) + RS_W'(rstart_reg) + RS_W'(i_reg) - RS_W'(cfg.padding);
    assign rprod = (RS_W+DIM_W)'(rsum) * (RS_W+DIM_W)'(cfg.in_cols);
    assign ifc   = FF_W'(i_reg) * FF_W'(cfg.filter_cols);
    assign fbase_full = (POS_W+FF_W)'(ch_reg) * (POS_W+FF_W)'(frfc_reg);

    always_ff @(posedge aclk) begin
        case (uop.op)
            OP_WAIT: begin
                if (s_valid) begin
                    orow_reg <= s_out_row;
                    ocol_reg <= s_out_col;
                    ch_reg   <= s_channel;
                end
            end
            OP_MUL: begin
                rstart_reg  <= ST_W'(orow_reg) * ST_W'(cfg.stride);
                cstart_reg  <= ST_W'(ocol_reg) * ST_W'(cfg.stride);
                rowbase_reg <= RB_W'(ch_reg) * RB_W'(cfg.in_rows);
                frfc_reg    <= FF_W'(cfg.filter_rows) * FF_W'(cfg.filter_cols);
                ch_ok_reg   <= DIM_W'(ch_reg) < cfg.in_depth;
            end
            OP_CHECK: begin
                i_lo_reg  <= row_ax.lo;
                i_hi_reg  <= row_ax.hi;
                j_lo_reg  <= col_ax.lo;
                j_hi_reg  <= col_ax.hi;
                i_reg     <= row_ax.lo;
                n_reg     <= '0;
                fbase_reg <= fbase_full[FIDX_W-1:0];
            end
            OP_ROW: begin
                rowaddr_reg <= rprod[IIDX_W-1:0];
                frow_reg    <= fbase_reg + FIDX_W'(ifc);
                j_reg       <= j_lo_reg;
            end
            OP_TAP: begin
                if (emit_ok) begin
                    n_reg <= n_reg + N_W'(1);
                    if (row_end) i_reg <= i_reg + FLT_W'(1);
                    else j_reg <= j_reg + FLT_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (emit_fire) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_fire) begin
            if (uop.op == OP_TAP) begin
                m_input_index_reg  <= rowaddr_reg + IIDX_W'(cstart_reg) + IIDX_W'(j_reg)
                                    - IIDX_W'(cfg.padding);
                m_filter_index_reg <= frow_reg + FIDX_W'(j_reg);
                m_valid_res_reg    <= 1'b1;
                m_range_error_reg  <= 1'b0;
                m_last_reg         <= tap_last;
            end else begin
                m_input_index_reg  <= '0;
                m_filter_index_reg <= '0;
                m_valid_res_reg    <= 1'b0;
                m_range_error_reg  <= (uop.op == OP_ERR);
                m_last_reg         <= 1'b1;
            end
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_input_index  = m_input_index_reg;
    assign m_filter_index = m_filter_index_reg;
    assign m_valid_res    = m_valid_res_reg;
    assign m_range_error  = m_range_error_reg;
    assign m_last         = m_last_reg;

    a_err_is_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_range_error_reg |-> m_last_reg && !m_valid_res_reg)
        else $error("range error request not a lone final result");

    a_empty_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_valid_res_reg |->
            m_last_reg && (m_input_index_reg == '0) && (m_filter_index_reg == '0))
        else $error("non-pair request carries an address");

    a_tap_bounds: assert property (@(posedge aclk) disable iff (!aresetn)
        uop.op == OP_TAP |->
            (i_reg >= i_lo_reg) && (i_reg <= i_hi_reg)
            && (j_reg >= j_lo_reg) && (j_reg <= j_hi_reg))
        else $error("tap walk outside the unpadded window");

endmodule

### rtl/conv_window_index_map_unit.sv
// Top level of the convolution window index map: config, microcode sequencer and datapath.
//
//  channel  dir  handshake          payload
//  s_       in   s_valid / s_ready  s_out_row, s_out_col, s_channel
//  m_       out  m_valid / m_ready  m_input_index, m_filter_index, m_valid_res,
//                                   m_range_error, m_last
//  cfg_     in   cfg_wr_en          cfg_index, cfg_data
//
// Each item steps through accept, setup multiply and bound check, then one
// row setup step for each filter row that lands in the plane and one tap
// step per emitted pair (at most 64). Range-error and empty windows emit one
// result from their own step after the bound check. The row-address multiply
// per row and the single output register set the pace of a window.
// Reset is synchronous, active low; no clearing pass is needed.
// A stalled result holds the tap step; a new request is taken only in the idle step.
module conv_window_index_map_unit #(
    parameter int MAX_DIM    = cwim_pkg::MAX_DIM_DEF,
    parameter int MAX_DEPTH  = cwim_pkg::MAX_DEPTH_DEF,
    parameter int MAX_FILTER = cwim_pkg::MAX_FILTER_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [cwim_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cwim_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [cwim_pkg::POS_W-1:0]      s_out_row,
    input  logic [cwim_pkg::POS_W-1:0]      s_out_col,
    input  logic [cwim_pkg::POS_W-1:0]      s_channel,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [cwim_pkg::IIDX_W-1:0]     m_input_index,
    output logic [cwim_pkg::FIDX_W-1:0]     m_filter_index,
    output logic                            m_valid_res,
    output logic                            m_range_error,
    output logic                            m_last
);
    import cwim_pkg::*;

    cwim_cfg_t cfg;
    uword_t    uop;
    flags_t    flags;

    cwim_cfg #(
        .MAX_DIM    (MAX_DIM),
        .MAX_DEPTH  (MAX_DEPTH),
        .MAX_FILTER (MAX_FILTER)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    cwim_useq u_useq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .uop     (uop)
    );

    cwim_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg            (cfg),
        .uop            (uop),
        .flags          (flags),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_out_row      (s_out_row),
        .s_out_col      (s_out_col),
        .s_channel      (s_channel),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_input_index  (m_input_index),
        .m_filter_index (m_filter_index),
        .m_valid_res    (m_valid_res),
        .m_range_error  (m_range_error),
        .m_last         (m_last)
    );

endmodule

### test/tb_conv_window_index_map_unit.sv
// Testbench for conv_window_index_map_unit: directed and random windows checked against a predictor.
`timescale 1ns / 1ps

module tb_conv_window_index_map_unit;
    import cwim_pkg::*;

    localparam int SETTLE_CYCLES = 6;

    typedef struct packed {
        logic [IIDX_W-1:0] input_index;
        logic [FIDX_W-1:0] filter_index;
        logic              valid_res;
        logic              range_error;
        logic              last;
    } tap_pair_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    logic [POS_W-1:0]      s_out_row = '0;
    logic [POS_W-1:0]      s_out_col = '0;
    logic [POS_W-1:0]      s_channel = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    logic [IIDX_W-1:0]     m_input_index;
    logic [FIDX_W-1:0]     m_filter_index;
    logic                  m_valid_res;
    logic                  m_range_error;
    logic                  m_last;

    // shadow of the geometry registers, as the block holds them after saturation
    int unsigned plane_rows  = 1;
    int unsigned plane_cols  = 1;
    int unsigned plane_depth = 1;
    int unsigned win_rows    = 1;
    int unsigned win_cols    = 1;
    int unsigned win_stride  = 1;
    int unsigned win_pad     = 0;

    tap_pair_t expected_taps[$];
    int        fail_count      = 0;
    int        sender_idle_pct = 37;
    int        recv_idle_pct   = 61;

    conv_window_index_map_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_out_row     (s_out_row),
        .s_out_col     (s_out_col),
        .s_channel     (s_channel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_input_index (m_input_index),
        .m_filter_index(m_filter_index),
        .m_valid_res   (m_valid_res),
        .m_range_error (m_range_error),
        .m_last        (m_last)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic int unsigned clamp_to(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int unsigned window_span(int unsigned size, int unsigned fsize);
        int unsigned padded;
        padded = size + 2 * win_pad;
        if (padded < fsize) return 0;
        return (padded - fsize) / win_stride + 1;
    endfunction

    function automatic void queue_tap(tap_pair_t p);
        expected_taps.insert(expected_taps.size(), p);
    endfunction

    task automatic predict_window(input logic [POS_W-1:0] row, col, ch);
        int unsigned nrows, ncols, r, c, ii, fi, n;
        int unsigned prow, pcol, pch;
        tap_pair_t   p;
        prow  = 32'(row);
        pcol  = 32'(col);
        pch   = 32'(ch);
        nrows = window_span(plane_rows, win_rows);
        ncols = window_span(plane_cols, win_cols);
        n = 0;
        p = '0;
        if (prow >= nrows || pcol >= ncols || pch >= plane_depth) begin
            p.range_error = 1'b1;
            p.last        = 1'b1;
            queue_tap(p);
            return;
        end
        for (int i = 0; i < win_rows && n < MAX_RESULTS; i++) begin
            r = prow * win_stride + i;
            if (r < win_pad || r >= win_pad + plane_rows) continue;
            for (int j = 0; j < win_cols && n < MAX_RESULTS; j++) begin
                c = pcol * win_stride + j;
                if (c < win_pad || c >= win_pad + plane_cols) continue;
                ii = (pch * plane_rows + (r - win_pad)) * plane_cols + (c - win_pad);
                fi = pch * win_rows * win_cols + i * win_cols + j;
                p.input_index  = ii[IIDX_W-1:0];
                p.filter_index = fi[FIDX_W-1:0];
                p.valid_res    = 1'b1;
                queue_tap(p);
                n++;
            end
        end
        if (n == 0) begin
            // window lies wholly in the padding border
            p = '0;
            p.last = 1'b1;
            queue_tap(p);
        end else begin
            expected_taps[expected_taps.size()-1].last = 1'b1;
        end
    endtask

    // called at a rising edge; returns at the edge that accepts the request
    task automatic send_window(input logic [POS_W-1:0] row, col, ch);
        int idle_n;
        idle_n = 0;
        while ($urandom_range(99) < sender_idle_pct) idle_n++;
        if (idle_n > 0) begin
            s_valid <= 1'b0;
            repeat (idle_n) @(posedge aclk);
        end
        predict_window(row, col, ch);
        s_valid   <= 1'b1;
        s_out_row <= row;
        s_out_col <= col;
        s_channel <= ch;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (expected_taps.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        case (idx)
            REG_IN_ROWS:     plane_rows  = clamp_to(32'(data), 1, MAX_DIM_DEF);
            REG_IN_COLS:     plane_cols  = clamp_to(32'(data), 1, MAX_DIM_DEF);
            REG_IN_DEPTH:    plane_depth = clamp_to(32'(data), 1, MAX_DEPTH_DEF);
            REG_FILTER_ROWS: win_rows    = clamp_to(32'(data[3:0]), 1, MAX_FILTER_DEF);
            REG_FILTER_COLS: win_cols    = clamp_to(32'(data[3:0]), 1, MAX_FILTER_DEF);
            REG_STRIDE:      win_stride  = clamp_to(32'(data[3:0]), 1, STRIDE_MAX);
            REG_PADDING:     win_pad     = 32'(data[2:0]);
            default: ;
        endcase
    endtask

    task automatic apply_geometry(input logic [CFG_DATA_W-1:0] rows, cols, depth,
                                  input logic [CFG_DATA_W-1:0] frows, fcols, step, pad);
        drain_results();
        set_reg(REG_IN_ROWS, rows);
        set_reg(REG_IN_COLS, cols);
        set_reg(REG_IN_DEPTH, depth);
        set_reg(REG_FILTER_ROWS, frows);
        set_reg(REG_FILTER_COLS, fcols);
        set_reg(REG_STRIDE, step);
        set_reg(REG_PADDING, pad);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            fail_count++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : result_check
        tap_pair_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_taps.size() == 0) begin
                fail_count++;
                $display("%0t: unexpected result: expected none, actual index %0d/%0d",
                         $time, m_input_index, m_filter_index);
            end else begin
                want = expected_taps.pop_front();
                compare_field("input_index", 32'(want.input_index), 32'(m_input_index));
                compare_field("filter_index", 32'(want.filter_index), 32'(m_filter_index));
                compare_field("valid_res", 32'(want.valid_res), 32'(m_valid_res));
                compare_field("range_error", 32'(want.range_error), 32'(m_range_error));
                compare_field("last", 32'(want.last), 32'(m_last));
            end
        end
    end

    // registers still at their reset values
    task automatic test_reset_defaults();
        send_window(0, 0, 0);
        send_window(1, 0, 0);
        send_window(0, 0, 1);
        send_window(63, 63, 63);
    endtask

    task automatic test_saturation();
        // 0 and 127 clamp, filter/stride use only the low nibble, padding the low 3 bits
        apply_geometry(7'd0, 7'd127, 7'h7F, 7'h7F, 7'd0, 7'h10, 7'h0F);
        send_window(7, 63, 63);
        send_window(0, 6, 0);
        send_window(8, 0, 0);
        apply_geometry(7'd65, 7'd64, 7'd0, 7'h1A, 7'h0F, 7'h0F, 7'h78);
        send_window(0, 0, 1);
        send_window(0, 7, 0);
        send_window(0, 0, 0);
    endtask

    task automatic test_padding_border();
        apply_geometry(7'd1, 7'd1, 7'd64, 7'd3, 7'd3, 7'd1, 7'd7);
        send_window(0, 0, 0);
        send_window(6, 6, 63);
        send_window(12, 12, 0);
        send_window(13, 0, 0);
        send_window(0, 13, 0);
    endtask

    task automatic test_extremes();
        apply_geometry(7'd64, 7'd64, 7'd64, 7'd8, 7'd8, 7'd1, 7'd0);
        send_window(56, 56, 63);
        send_window(0, 0, 0);
        send_window(57, 0, 0);
        apply_geometry(7'd64, 7'd64, 7'd5, 7'd8, 7'd8, 7'd8, 7'd7);
        send_window(8, 8, 4);
        send_window(0, 0, 5);
        // filter larger than the padded plane: no windows at all
        apply_geometry(7'd2, 7'd2, 7'd1, 7'd8, 7'd8, 7'd1, 7'd0);
        send_window(0, 0, 0);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_dim();
        case ($urandom_range(9))
            0:       return CFG_DATA_W'($urandom_range(0, 127));
            1, 2:    return CFG_DATA_W'($urandom_range(1, 64));
            default: return CFG_DATA_W'($urandom_range(1, 12));
        endcase
    endfunction

    task automatic random_geometry();
        logic [CFG_DATA_W-1:0] depth, frows, fcols, step, pad;
        depth = CFG_DATA_W'(($urandom_range(4) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(1, 64));
        frows = CFG_DATA_W'(($urandom_range(7) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(1, 8));
        fcols = CFG_DATA_W'(($urandom_range(7) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(1, 8));
        step  = CFG_DATA_W'(($urandom_range(7) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(1, 4));
        pad   = CFG_DATA_W'(($urandom_range(7) == 0) ? $urandom_range(0, 127)
                                                     : $urandom_range(0, 7));
        apply_geometry(pick_dim(), pick_dim(), depth, frows, fcols, step, pad);
    endtask

    task automatic test_random_phase(input int n_items, input int snd_pct, input int rcv_pct);
        int unsigned nrows, ncols;
        logic [POS_W-1:0] row, col, ch;
        sender_idle_pct = snd_pct;
        recv_idle_pct   = rcv_pct;
        for (int k = 0; k < n_items; k++) begin
            if (k % 23 == 0) random_geometry();
            nrows = window_span(plane_rows, win_rows);
            ncols = window_span(plane_cols, win_cols);
            if (nrows > 0 && ncols > 0 && $urandom_range(9) < 8) begin
                row = POS_W'($urandom_range(0, (nrows > 64) ? 63 : nrows - 1));
                col = POS_W'($urandom_range(0, (ncols > 64) ? 63 : ncols - 1));
                ch  = POS_W'($urandom_range(0, plane_depth - 1));
            end else begin
                row = POS_W'($urandom_range(0, 63));
                col = POS_W'($urandom_range(0, 63));
                ch  = POS_W'($urandom_range(0, 63));
            end
            send_window(row, col, ch);
            // hold off new requests until the block has caught up
            if ($urandom_range(39) == 0) drain_results();
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_saturation();
        test_padding_border();
        test_extremes();
        test_random_phase(137, 37, 61);
        test_random_phase(137, 61, 37);
        test_random_phase(136, 0, 0);
        drain_results();
        repeat (20) @(posedge aclk);
        if (fail_count == 0) begin
            $display("tb_conv_window_index_map_unit: PASS");
        end else begin
            $display("tb_conv_window_index_map_unit: FAIL");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("%0t: timeout with %0d results outstanding", $time, expected_taps.size());
        $display("tb_conv_window_index_map_unit: FAIL");
        $finish;
    end

endmodule
